### rtl/fbta_pkg.sv
// ----------------------------------------------------------------------------
// fbta_pkg
// shared constants, types and codes of the fractal block transform engine
// ----------------------------------------------------------------------------
package fbta_pkg;

   localparam int FRAME_DIM = 256;
   localparam int COORD_W   = $clog2(FRAME_DIM);
   localparam int ADDR_W    = 2 * COORD_W;
   localparam int MAX_BLOCK = 32;
   localparam int BLK_W     = 6;
   localparam int PIX_W     = 8;
   localparam int SUM_W     = 10;
   localparam int CON_W     = 16;
   localparam int BRI_W     = 17;
   localparam int PROD_W    = SUM_W + 1 + CON_W;
   localparam int T_W       = PROD_W + 2;
   localparam int FRAC_W    = 14;
   localparam int BRI_SHIFT = 10;
   localparam int HALF_LSB  = 8192;
   localparam int CLR_W     = ADDR_W + 1;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_APPLY = 2'd2,
      CMD_SWAP  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_FETCH,
      ST_MUL,
      ST_STORE
   } state_type;

endpackage

### rtl/fbta_if.sv
// ----------------------------------------------------------------------------
// fbta channel interfaces
// command channel and result channel, valid/ready transfer
// ----------------------------------------------------------------------------
interface fbta_req_if
   import fbta_pkg::*;
();
   logic                    valid;
   logic                    ready;
   cmd_type                 command;
   logic [7:0]              row;
   logic [7:0]              col;
   logic [7:0]              pixel_value;
   logic [5:0]              block_size;
   logic [7:0]              domain_row;
   logic [7:0]              domain_col;
   logic [2:0]              symmetry;
   logic signed [15:0]      contrast;
   logic signed [16:0]      brightness;
   logic                    no_average;

   modport source (output valid, command, row, col, pixel_value, block_size,
                   domain_row, domain_col, symmetry, contrast, brightness,
                   no_average, input ready);
   modport sink   (input valid, command, row, col, pixel_value, block_size,
                   domain_row, domain_col, symmetry, contrast, brightness,
                   no_average, output ready);
endinterface

interface fbta_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       done_res;

   modport source (output valid, read_data, done_res, input ready);
   modport sink   (input valid, read_data, done_res, output ready);
endinterface

### rtl/fbta_ram.sv
// ----------------------------------------------------------------------------
// fbta_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module fbta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/fbta_map_unit.sv
// ----------------------------------------------------------------------------
// fbta_map_unit
// shared scale-offset unit: registered product, then offset, round and clamp
// ----------------------------------------------------------------------------
module fbta_map_unit import fbta_pkg::*; (
   input  logic                    clock,
   input  logic                    load,
   input  logic [SUM_W-1:0]        sum,
   input  logic signed [CON_W-1:0] contrast,
   input  logic signed [BRI_W-1:0] brightness,
   output logic [PIX_W-1:0]        value
);
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [T_W-1:0]    t;

   // both operands widened to the full product width before the multiply
   assign prod_in = PROD_W'($signed({1'b0, sum})) * PROD_W'(contrast);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // t in units of 2^-14, half lsb added for rounding
   assign t = T_W'(prod_ff) + (T_W'(brightness) <<< BRI_SHIFT) + T_W'(HALF_LSB);

   always_comb begin
      if (t < 0) begin
         value = '0;
      end else if (t[T_W-1:FRAC_W] > (T_W-FRAC_W)'(255)) begin
         value = '1;
      end else begin
         value = t[FRAC_W+PIX_W-1:FRAC_W];
      end
   end
endmodule

### rtl/fractal_block_transform_apply.sv
// ----------------------------------------------------------------------------
// fractal_block_transform_apply
// two-frame fractal decoding engine: pixel access, block map and frame swap
// ----------------------------------------------------------------------------
// usage:
//  req_chan carries one command per transfer: write pixel, read pixel,
//  apply transform or swap frames. rsp_chan returns exactly one result per
//  command (read_data for a read, else zero, and done_res set).
//  write and swap answer one cycle after the transfer; a read answers from
//  the read state, which passes the registered frame memory data to the
//  result register. an apply walks the range block pixel by pixel with one
//  frame memory port: four reads (one in pyramid mode), a multiply and a
//  store. block size 0 answers at once.
//  req_chan.ready is low while a command is in work and while a result is
//  waiting that the receiver does not take; a stalled result holds.
//  after reset the block clears all of frame a, one pixel a cycle, and takes no
//  command meanwhile.
// ----------------------------------------------------------------------------
module fractal_block_transform_apply import fbta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   fbta_req_if.sink    req_chan,
   fbta_rsp_if.source  rsp_chan
);
   state_type state_ff, state_in;

   // latched command
   logic [COORD_W-1:0]     rx_ff, ry_ff, dx_ff, dy_ff;
   logic [BLK_W-1:0]       s_ff;
   logic [2:0]             sym_ff;
   logic signed [CON_W-1:0] con_ff;
   logic signed [BRI_W-1:0] bri_ff;
   logic                   single_ff;

   // walk counters
   logic [BLK_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [2:0]       k_ff, k_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic             cur_sel_ff, cur_sel_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_data_ff, rsp_data_in;

   // memory ports seen as current and next frame
   logic              cur_we, nxt_we;
   logic [ADDR_W-1:0] cur_addr, nxt_addr;
   logic [PIX_W-1:0]  cur_wdata, nxt_wdata, cur_rdata;
   logic [PIX_W-1:0]  ram_a_rdata, ram_b_rdata;

   logic              accept;
   logic [BLK_W-1:0]  s_sat;
   logic [COORD_W-1:0] dom_r, dom_c, rng_i, rng_j;
   logic [COORD_W-1:0] ac, bc, sm1;
   logic [2:0]        nreads;
   logic              unit_load;
   logic [PIX_W-1:0]  map_value;

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.done_res  = 1'b1;

   assign s_sat = (req_chan.block_size > BLK_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK)
                                                             : req_chan.block_size;

   // domain pixel for this step; k bit 0 steps the row, bit 1 the column
   assign ac  = COORD_W'(a_ff);
   assign bc  = COORD_W'(b_ff);
   assign sm1 = COORD_W'(s_ff) - COORD_W'(1);
   always_comb begin
      if (single_ff) begin
         dom_r = (dx_ff >> 1) + ac;
         dom_c = (dy_ff >> 1) + bc;
      end else begin
         dom_r = dx_ff + COORD_W'({a_ff, 1'b0}) + COORD_W'(k_ff[0]);
         dom_c = dy_ff + COORD_W'({b_ff, 1'b0}) + COORD_W'(k_ff[1]);
      end
   end

   // range pixel placement under the eight symmetries
   always_comb begin
      case (sym_ff)
         3'd0: begin rng_i = rx_ff + ac;         rng_j = ry_ff + bc;         end
         3'd1: begin rng_i = rx_ff + bc;         rng_j = ry_ff + sm1 - ac;   end
         3'd2: begin rng_i = rx_ff + sm1 - bc;   rng_j = ry_ff + ac;         end
         3'd3: begin rng_i = rx_ff + sm1 - ac;   rng_j = ry_ff + sm1 - bc;   end
         3'd4: begin rng_i = rx_ff + ac;         rng_j = ry_ff + sm1 - bc;   end
         3'd5: begin rng_i = rx_ff + sm1 - ac;   rng_j = ry_ff + bc;         end
         3'd6: begin rng_i = rx_ff + bc;         rng_j = ry_ff + ac;         end
         default: begin rng_i = rx_ff + sm1 - bc; rng_j = ry_ff + sm1 - ac; end
      endcase
   end

   assign nreads = single_ff ? 3'd1 : 3'd4;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      sum_in       = sum_ff;
      clr_in       = clr_ff;
      cur_sel_in   = cur_sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      cur_we       = 1'b0;
      cur_addr     = {req_chan.row, req_chan.col};
      cur_wdata    = req_chan.pixel_value;
      nxt_we       = 1'b0;
      nxt_addr     = {rng_i, rng_j};
      nxt_wdata    = map_value;
      unit_load    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cur_we    = 1'b1;
            cur_addr  = clr_ff[ADDR_W-1:0];
            cur_wdata = '0;
            clr_in    = clr_ff + CLR_W'(1);
            if (clr_ff[ADDR_W-1:0] == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               a_in = '0;
               b_in = '0;
               k_in = '0;
               case (req_chan.command)
                  CMD_WRITE: begin
                     cur_we       = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  CMD_APPLY: begin
                     if (s_sat == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     cur_sel_in   = !cur_sel_ff;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = cur_rdata;
            state_in     = ST_IDLE;
         end
         ST_FETCH: begin
            // issue read k, gather read k-1
            cur_addr = {dom_r, dom_c};
            k_in     = k_ff + 3'd1;
            if (k_ff == '0) begin
               sum_in = '0;
            end else if (single_ff) begin
               sum_in = {cur_rdata, 2'b00};
            end else begin
               sum_in = sum_ff + SUM_W'(cur_rdata);
            end
            if (k_ff == nreads) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            unit_load = 1'b1;
            state_in  = ST_STORE;
         end
         ST_STORE: begin
            nxt_we   = 1'b1;
            k_in     = '0;
            state_in = ST_FETCH;
            if (b_ff == s_ff - BLK_W'(1)) begin
               b_in = '0;
               a_in = a_ff + BLK_W'(1);
               if (a_ff == s_ff - BLK_W'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  state_in     = ST_IDLE;
               end
            end else begin
               b_in = b_ff + BLK_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cur_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_sel_ff   <= cur_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      k_ff        <= k_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         rx_ff     <= req_chan.row;
         ry_ff     <= req_chan.col;
         dx_ff     <= req_chan.domain_row;
         dy_ff     <= req_chan.domain_col;
         s_ff      <= s_sat;
         sym_ff    <= req_chan.symmetry;
         con_ff    <= req_chan.contrast;
         bri_ff    <= req_chan.brightness;
         single_ff <= req_chan.no_average;
      end
   end

   // the current frame takes the cur port, the other the nxt port
   assign cur_rdata = cur_sel_ff ? ram_b_rdata : ram_a_rdata;

   fbta_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_DIM * FRAME_DIM)) u_frame_a (
      .clock (clock),
      .we    (cur_sel_ff ? nxt_we : cur_we),
      .addr  (cur_sel_ff ? nxt_addr : cur_addr),
      .wdata (cur_sel_ff ? nxt_wdata : cur_wdata),
      .rdata (ram_a_rdata)
   );

   fbta_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_DIM * FRAME_DIM)) u_frame_b (
      .clock (clock),
      .we    (cur_sel_ff ? cur_we : nxt_we),
      .addr  (cur_sel_ff ? cur_addr : nxt_addr),
      .wdata (cur_sel_ff ? cur_wdata : nxt_wdata),
      .rdata (ram_b_rdata)
   );

   fbta_map_unit u_map (
      .clock      (clock),
      .load       (unit_load),
      .sum        (sum_ff),
      .contrast   (con_ff),
      .brightness (bri_ff),
      .value      (map_value)
   );

`ifndef NO_ASSERTIONS
   // walk counters stay inside the range block
   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (a_ff < s_ff && b_ff < s_ff && k_ff <= nreads))
      else $error("walk counters outside range block");

   // the clearing pass runs only after reset
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
      else $error("clearing pass re-entered");

   // a swap transfer flips the frame select
   a_swap_flip: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.command == CMD_SWAP) |=> (cur_sel_ff != $past(cur_sel_ff)))
      else $error("swap did not flip frames");

   // a new result never lands on one still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result overwritten");
`endif
endmodule

### dv/fbta_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbta_checker
// watches the command and result channels, keeps its own copy of both
// frames, predicts each result and compares it with what the block returns
// ----------------------------------------------------------------------------
module fbta_checker import fbta_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   fbta_req_if   req_chan,
   fbta_rsp_if   rsp_chan,
   output int    fail_count,
   output int    pending
);

   typedef struct packed {
      logic [7:0] read_data;
      logic       done_res;
   } answer_type;

   answer_type answers[$];
   logic [7:0] frame_img[2][FRAME_DIM*FRAME_DIM];
   logic       cur_sel;

   function automatic int pix_index(int r, int c);
      return (r % FRAME_DIM) * FRAME_DIM + (c % FRAME_DIM);
   endfunction

   // affine map in units of 2^-14, floor then clamp
   function automatic logic [7:0] shade(longint sum4, longint con, longint bri);
      longint t;
      longint q;
      t = sum4 * con + bri * 1024 + HALF_LSB;
      if (t < 0) return 8'd0;
      q = t >>> FRAC_W;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   task automatic map_block();
      int     s, rx, ry, dx, dy, i, j, ii, jj;
      longint sum4, con, bri;
      logic   src, dst;
      src = cur_sel;
      dst = ~cur_sel;
      rx  = int'(req_chan.row);
      ry  = int'(req_chan.col);
      dx  = int'(req_chan.domain_row);
      dy  = int'(req_chan.domain_col);
      con = longint'(req_chan.contrast);
      bri = longint'(req_chan.brightness);
      s   = int'(req_chan.block_size);
      if (s > MAX_BLOCK) s = MAX_BLOCK;
      for (int a = 0; a < s; a++) begin
         for (int b = 0; b < s; b++) begin
            if (req_chan.no_average) begin
               sum4 = 4 * longint'(frame_img[src][pix_index((dx >> 1) + a, (dy >> 1) + b)]);
            end else begin
               ii = dx + 2 * a;
               jj = dy + 2 * b;
               sum4 = longint'(frame_img[src][pix_index(ii, jj)])
                    + longint'(frame_img[src][pix_index(ii + 1, jj)])
                    + longint'(frame_img[src][pix_index(ii, jj + 1)])
                    + longint'(frame_img[src][pix_index(ii + 1, jj + 1)]);
            end
            case (req_chan.symmetry)
               3'd0: begin i = rx + a;         j = ry + b;         end
               3'd1: begin i = rx + b;         j = ry + s - 1 - a; end
               3'd2: begin i = rx + s - 1 - b; j = ry + a;         end
               3'd3: begin i = rx + s - 1 - a; j = ry + s - 1 - b; end
               3'd4: begin i = rx + a;         j = ry + s - 1 - b; end
               3'd5: begin i = rx + s - 1 - a; j = ry + b;         end
               3'd6: begin i = rx + b;         j = ry + a;         end
               default: begin i = rx + s - 1 - b; j = ry + s - 1 - a; end
            endcase
            frame_img[dst][pix_index(i, j)] = shade(sum4, con, bri);
         end
      end
   endtask

   task automatic note_mismatch(string what, int exp_v, int act_v);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch %s: expected %0d actual %0d at %0t", what, exp_v, act_v, $realtime);
   endtask

   always @(posedge clock) begin
      answer_type exp_a;
      answer_type nxt;
      int         idx;
      if (reset) begin
         answers.delete();
         cur_sel    = 1'b0;
         fail_count = 0;
         for (int k = 0; k < FRAME_DIM * FRAME_DIM; k++) frame_img[0][k] = 8'd0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (answers.size() == 0) begin
               note_mismatch("unexpected result, read_data", -1, int'(rsp_chan.read_data));
            end else begin
               exp_a = answers.pop_front();
               if (rsp_chan.read_data !== exp_a.read_data)
                  note_mismatch("read_data", int'(exp_a.read_data),
                                int'(rsp_chan.read_data));
               if (rsp_chan.done_res !== exp_a.done_res)
                  note_mismatch("done_res", int'(exp_a.done_res), int'(rsp_chan.done_res));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            nxt.read_data = 8'd0;
            nxt.done_res  = 1'b1;
            idx = pix_index(int'(req_chan.row), int'(req_chan.col));
            case (req_chan.command)
               CMD_WRITE: frame_img[cur_sel][idx] = req_chan.pixel_value;
               CMD_READ:  nxt.read_data = frame_img[cur_sel][idx];
               CMD_APPLY: map_block();
               default:   cur_sel = ~cur_sel;
            endcase
            answers.push_back(nxt);
         end
      end
      pending = answers.size();
   end

endmodule

### dv/tb_fractal_block_transform_apply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractal_block_transform_apply
// drives pixel writes, reads, block maps and frame swaps with random gaps
// and stalls; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_fractal_block_transform_apply;
   import fbta_pkg::*;

   localparam int NPIX = FRAME_DIM * FRAME_DIM;

   typedef struct {
      cmd_type     command;
      logic [7:0]  row, col, pixel_value, domain_row, domain_col;
      logic [5:0]  block_size;
      logic [2:0]  symmetry;
      logic [15:0] contrast;
      logic [16:0] brightness;
      logic        no_average;
   } fbta_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   sent_count = 0;

   // which pixels of each frame hold defined data, mirrored from the commands
   bit   pix_known[2][NPIX];
   bit   stim_sel = 1'b0;

   fbta_req_if req_chan();
   fbta_rsp_if rsp_chan();

   fractal_block_transform_apply dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   fbta_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // hard stop well past the slowest legal run (clear pass plus big blocks)
   initial begin
      #60ms;
      $display("Simulation FAILED");
      $finish;
   end

   // gap length: mostly none or short, now and then long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic int pix_index(int r, int c);
      return (r % FRAME_DIM) * FRAME_DIM + (c % FRAME_DIM);
   endfunction

   // true when every pixel of an n x n square (wrapping) is defined
   function automatic bit square_known(bit f, int r0, int c0, int n);
      for (int a = 0; a < n; a++)
         for (int b = 0; b < n; b++)
            if (!pix_known[f][pix_index(r0 + a, c0 + b)]) return 1'b0;
      return 1'b1;
   endfunction

   // keep the definedness map in step with the command stream
   task automatic track_cmd(fbta_cmd_type c);
      int s;
      case (c.command)
         CMD_WRITE: pix_known[stim_sel][pix_index(c.row, c.col)] = 1'b1;
         CMD_APPLY: begin
            s = (c.block_size > MAX_BLOCK) ? MAX_BLOCK : c.block_size;
            // every symmetry lands on the same range square
            for (int a = 0; a < s; a++)
               for (int b = 0; b < s; b++)
                  pix_known[~stim_sel][pix_index(c.row + a, c.col + b)] = 1'b1;
         end
         CMD_SWAP: stim_sel = ~stim_sel;
         default: ;
      endcase
   endtask

   // domain footprint of an apply must be fully defined in the current frame
   function automatic bit domain_ok(fbta_cmd_type c);
      int s;
      s = (c.block_size > MAX_BLOCK) ? MAX_BLOCK : c.block_size;
      if (s == 0) return 1'b1;
      if (c.no_average) return square_known(stim_sel, c.domain_row >> 1, c.domain_col >> 1, s);
      return square_known(stim_sel, c.domain_row, c.domain_col, 2 * s);
   endfunction

   task automatic send_cmd(fbta_cmd_type c);
      int g;
      track_cmd(c);
      @(negedge clock);
      req_chan.valid       = 1'b1;
      req_chan.command     = c.command;
      req_chan.row         = c.row;
      req_chan.col         = c.col;
      req_chan.pixel_value = c.pixel_value;
      req_chan.block_size  = c.block_size;
      req_chan.domain_row  = c.domain_row;
      req_chan.domain_col  = c.domain_col;
      req_chan.symmetry    = c.symmetry;
      req_chan.contrast    = c.contrast;
      req_chan.brightness  = c.brightness;
      req_chan.no_average  = c.no_average;
      // wait for the transfer
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
      g = gap_len();
      if (g > 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   function automatic fbta_cmd_type blank_cmd(cmd_type op);
      fbta_cmd_type c;
      c.command     = op;
      c.row         = 8'($urandom);
      c.col         = 8'($urandom);
      c.pixel_value = 8'($urandom);
      c.block_size  = 6'($urandom);
      c.domain_row  = 8'($urandom);
      c.domain_col  = 8'($urandom);
      c.symmetry    = 3'($urandom);
      c.contrast    = 16'($urandom);
      c.brightness  = 17'($urandom);
      c.no_average  = 1'($urandom);
      return c;
   endfunction

   function automatic fbta_cmd_type mk_apply(int r, int c0, int s, int dr, int dc, int sym,
                                             int con, int bri, bit pyr);
      fbta_cmd_type c;
      c = blank_cmd(CMD_APPLY);
      c.row = 8'(r); c.col = 8'(c0); c.block_size = 6'(s);
      c.domain_row = 8'(dr); c.domain_col = 8'(dc);
      c.symmetry = 3'(sym); c.contrast = 16'(con); c.brightness = 17'(bri);
      c.no_average = pyr;
      return c;
   endfunction

   // random apply: mostly small blocks, typical contrast, a share of raw values
   function automatic fbta_cmd_type rand_apply();
      fbta_cmd_type c;
      int r;
      c = blank_cmd(CMD_APPLY);
      r = $urandom_range(0, 99);
      if (r < 60)      c.block_size = 6'($urandom_range(1, 4));
      else if (r < 85) c.block_size = 6'($urandom_range(5, 12));
      else if (r < 90) c.block_size = 6'd0;
      else if (r < 95) c.block_size = 6'($urandom_range(33, 63));
      else             c.block_size = 6'd32;
      if ($urandom_range(0, 3) != 0) begin
         c.contrast   = 16'($urandom_range(0, 5000) - 1000);
         c.brightness = 17'($urandom_range(0, 2400) - 400);
      end
      return c;
   endfunction

   task automatic send_random();
      fbta_cmd_type c;
      int r;
      bit found;
      r = $urandom_range(0, 99);
      found = 1'b0;
      if (r < 30) begin
         c = blank_cmd(CMD_WRITE);
         found = 1'b1;
      end else if (r < 60) begin
         for (int k = 0; k < 30 && !found; k++) begin
            c = blank_cmd(CMD_READ);
            found = pix_known[stim_sel][pix_index(c.row, c.col)];
         end
      end else if (r < 90) begin
         for (int k = 0; k < 30 && !found; k++) begin
            c = rand_apply();
            found = domain_ok(c);
         end
      end else begin
         c = blank_cmd(CMD_SWAP);
         found = 1'b1;
      end
      // no legal pick found: fall back to a write, which is always legal
      if (!found) c = blank_cmd(CMD_WRITE);
      send_cmd(c);
   endtask

   // result side: random ready, plus one long hold while commands keep coming
   initial begin
      bit held;
      held = 1'b0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         rsp_chan.ready = 1'b1;
         repeat ($urandom_range(0, 100) < 10 ? $urandom_range(20, 60) : $urandom_range(0, 6))
            @(negedge clock);
         @(negedge clock);
         rsp_chan.ready = 1'b0;
         if (sent_count >= 30 && !held) begin
            // long stall so the block fills and holds off the command side
            held = 1'b1;
            repeat (599) @(negedge clock);
         end else begin
            repeat (gap_len()) @(negedge clock);
         end
      end
   end

   initial begin
      fbta_cmd_type c;
      req_chan.valid       = 1'b0;
      req_chan.command     = CMD_WRITE;
      req_chan.row         = '0;
      req_chan.col         = '0;
      req_chan.pixel_value = '0;
      req_chan.block_size  = '0;
      req_chan.domain_row  = '0;
      req_chan.domain_col  = '0;
      req_chan.symmetry    = '0;
      req_chan.contrast    = '0;
      req_chan.brightness  = '0;
      req_chan.no_average  = 1'b0;
      // frame a is cleared by reset, frame b starts undefined
      for (int k = 0; k < NPIX; k++) pix_known[0][k] = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: pixel extremes
      c = blank_cmd(CMD_WRITE); c.row = 0;   c.col = 0;   c.pixel_value = 8'hff; send_cmd(c);
      c = blank_cmd(CMD_WRITE); c.row = 255; c.col = 255; c.pixel_value = 8'h00; send_cmd(c);
      c = blank_cmd(CMD_WRITE); c.row = 1;   c.col = 0;   c.pixel_value = 8'h80; send_cmd(c);
      c = blank_cmd(CMD_READ);  c.row = 0;   c.col = 0;   send_cmd(c);
      c = blank_cmd(CMD_READ);  c.row = 255; c.col = 255; send_cmd(c);
      c = blank_cmd(CMD_READ);  c.row = 7;   c.col = 200; send_cmd(c);
      // every symmetry, unit contrast around the origin
      for (int s = 0; s < 8; s++)
         send_cmd(mk_apply(16 * s, 8, 3, 0, 0, s, 4096, $urandom_range(0, 64), 1'b0));
      // clamp low and high, raw field extremes
      send_cmd(mk_apply(0, 100, 4, 0, 0, 0, -32768, -65536, 1'b0));
      send_cmd(mk_apply(4, 100, 4, 0, 0, 0, 32767, 65535, 1'b0));
      // pyramid mode, and wrapping range and domain coordinates
      send_cmd(mk_apply(40, 40, 4, 2, 0, 0, 4096, 0, 1'b1));
      send_cmd(mk_apply(254, 254, 5, 250, 252, 3, 3000, 100, 1'b0));
      send_cmd(mk_apply(60, 60, 3, 255, 255, 6, 4096, 8, 1'b1));
      // empty block and saturated block size
      send_cmd(mk_apply(90, 90, 0, 0, 0, 0, 4096, 0, 1'b0));
      send_cmd(mk_apply(160, 160, 63, 10, 20, 7, 2048, 512, 1'b0));
      // swap, look at the mapped frame, swap back
      send_cmd(blank_cmd(CMD_SWAP));
      c = blank_cmd(CMD_READ); c.row = 0; c.col = 8; send_cmd(c);
      c = blank_cmd(CMD_READ); c.row = 191; c.col = 191; send_cmd(c);
      send_cmd(blank_cmd(CMD_SWAP));

      for (int n = 0; n < 115; n++) begin
         if (n == 70) begin
            // quiet the command side until everything has come back
            @(negedge clock);
            req_chan.valid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         send_random();
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### fractal_block_transform_apply.f
rtl/fbta_pkg.sv
rtl/fbta_if.sv
rtl/fbta_ram.sv
rtl/fbta_map_unit.sv
rtl/fractal_block_transform_apply.sv
dv/fbta_checker.sv
dv/tb_fractal_block_transform_apply.sv
